// ===== sv/ehash_pkg.sv =====
// shared constants, codes and types of the extendible hash table
package ehash_pkg;

  localparam int SLOTS_PER_BUCKET_DEF = 16;
  localparam int MAX_DIRECTORY_DEF    = 1024;
  localparam int BUCKET_POOL_DEF      = 1024;
  localparam int INITIAL_DEPTH_DEF    = 4;

  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 64;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  localparam int MIX_STEPS = 7;
  localparam int MIX_SH_A  = 21;
  localparam int MIX_SH_B  = 24;
  localparam int MIX_SH_C  = 3;
  localparam int MIX_SH_D  = 8;
  localparam int MIX_SH_E  = 14;
  localparam int MIX_SH_F  = 2;
  localparam int MIX_SH_G  = 4;
  localparam int MIX_SH_H  = 28;
  localparam int MIX_SH_I  = 31;

  typedef enum logic [1:0] {
    MODE_SEARCH,
    MODE_INSERT,
    MODE_UPDATE,
    MODE_REMOVE
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE,
    STAT_ABSENT,
    STAT_FULL
  } status_t;

  typedef enum logic [5:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_DIR_RD,
    ST_DIR_WT,
    ST_BKT_WT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_INS,
    ST_SPLIT,
    ST_DBL_RD,
    ST_DBL_WR,
    ST_FREE_WT,
    ST_RELINK,
    ST_LD_B,
    ST_LD_NB,
    ST_DC_DEC,
    ST_DC_INC,
    ST_MV_RD,
    ST_MV_WT,
    ST_MV_HASH,
    ST_MASK_B,
    ST_MASK_NB,
    ST_MG_DIR,
    ST_MG_DWT,
    ST_MG_BWT,
    ST_MG_BUD,
    ST_MG_BWT2,
    ST_MG_LDWT,
    ST_MG_RELINK,
    ST_MG_FREE,
    ST_MG_DC1,
    ST_MG_DC2,
    ST_MG_LD,
    ST_MG_GD
  } state_t;

endpackage

// ===== sv/ehash_ram.sv =====
// generic single write port ram with registered read
module ehash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ehash_mix.sv =====
// iterative 64-bit shift-add-xor key mixer, one step per cycle
module ehash_mix (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [ehash_pkg::KEY_W-1:0] din,
  output logic                       done,
  output logic [ehash_pkg::KEY_W-1:0] dout
);
  import ehash_pkg::*;

  localparam int STEP_W = $clog2(MIX_STEPS);

  logic [KEY_W-1:0]  k_r, k_nxt, k_step;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    case (step_r)
      STEP_W'(0): k_step = (~k_r) + (k_r << MIX_SH_A);
      STEP_W'(1): k_step = k_r ^ (k_r >> MIX_SH_B);
      STEP_W'(2): k_step = k_r + (k_r << MIX_SH_C) + (k_r << MIX_SH_D);
      STEP_W'(3): k_step = k_r ^ (k_r >> MIX_SH_E);
      STEP_W'(4): k_step = k_r + (k_r << MIX_SH_F) + (k_r << MIX_SH_G);
      STEP_W'(5): k_step = k_r ^ (k_r >> MIX_SH_H);
      default:    k_step = k_r + (k_r << MIX_SH_I);
    endcase
  end

  always_comb begin
    k_nxt    = k_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      k_nxt    = din;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      k_nxt    = k_step;
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(MIX_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    k_r    <= k_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign dout = k_r;

endmodule

// ===== sv/extendible_hash_table.sv =====
// extendible hash table top level: sequencer, directory and bucket stores
//
// Command port: a beat (in_mode, in_key, in_value) is taken on a rising edge
// with start high and busy low. busy stays high until the result is out.
// Each beat gives one result beat: out_valid is high for exactly one cycle
// with out_status and out_found_value; the receiver cannot hold it off, and
// a new command may be started in that same cycle.
// A command runs key mixing, the directory and bucket reads, then the bucket
// scan, which skips empty slots and reads and compares each used slot.
// A split adds a copy of every directory entry when the directory doubles,
// a relink of the directory entries that move to the new bucket, and a
// rehash through the mixer of each used slot of the bucket.
// A merge step adds its directory and buddy checks plus its relink; remove
// repeats it while buckets keep merging. The mixer and the slot stores are
// shared by lookup and split, so one command runs at a time.
// Reset: a clearing pass sets up the directory, depths, slot masks and free
// queue; busy is high meanwhile.
module extendible_hash_table #(
  parameter int SLOTS_PER_BUCKET = ehash_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int MAX_DIRECTORY    = ehash_pkg::MAX_DIRECTORY_DEF,
  parameter int BUCKET_POOL      = ehash_pkg::BUCKET_POOL_DEF,
  parameter int INITIAL_DEPTH    = ehash_pkg::INITIAL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ehash_pkg::MODE_W-1:0]   in_mode,
  input  logic [ehash_pkg::KEY_W-1:0]    in_key,
  input  logic [ehash_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  output logic [ehash_pkg::STATUS_W-1:0] out_status,
  output logic [ehash_pkg::VALUE_W-1:0]  out_found_value
);
  import ehash_pkg::*;

  localparam int S          = SLOTS_PER_BUCKET;
  localparam int SI_W       = $clog2(S);
  localparam int SC_W       = $clog2(S + 1);
  localparam int BKT_W      = $clog2(BUCKET_POOL);
  localparam int FCNT_W     = $clog2(BUCKET_POOL + 1);
  localparam int DIR_AW     = $clog2(MAX_DIRECTORY);
  localparam int MAX_DEPTH  = $clog2(MAX_DIRECTORY + 1) - 1;
  localparam int GD_W       = $clog2(MAX_DEPTH + 1);
  localparam int JW         = MAX_DEPTH + 2;
  localparam int SLOT_DEPTH = BUCKET_POOL * S;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int INIT_BKTS  = 1 << INITIAL_DEPTH;
  localparam int CLR_LEN    = (MAX_DIRECTORY > BUCKET_POOL) ? MAX_DIRECTORY : BUCKET_POOL;
  localparam int CLR_W      = $clog2(CLR_LEN);

  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [BKT_W-1:0] b,
                                                   input logic [SI_W-1:0] i);
    slot_addr = SLOT_AW'(b) * SLOT_AW'(S) + SLOT_AW'(i);
  endfunction

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [KEY_W-1:0]    h_r, h_nxt;
  logic [GD_W-1:0]     gd_r, gd_nxt;
  logic [BKT_W-1:0]    head_r, head_nxt;
  logic [FCNT_W-1:0]   fcnt_r, fcnt_nxt;
  logic [FCNT_W-1:0]   dc_r [MAX_DEPTH+1];
  logic [FCNT_W-1:0]   dc_nxt [MAX_DEPTH+1];
  logic [CLR_W-1:0]    clr_r, clr_nxt;
  logic [BKT_W-1:0]    clr_bkt_r, clr_bkt_nxt;
  logic                retry_r, retry_nxt;
  logic [JW-1:0]       idx_r, idx_nxt;
  logic [JW-1:0]       midx_r, midx_nxt;
  logic [JW-1:0]       j_r, j_nxt;
  logic [BKT_W-1:0]    b_r, b_nxt;
  logic [BKT_W-1:0]    nb_r, nb_nxt;
  logic [GD_W-1:0]     ld_r, ld_nxt;
  logic [S-1:0]        mask_r, mask_nxt;
  logic [S-1:0]        nbmask_r, nbmask_nxt;
  logic [SC_W-1:0]     cnt_r, cnt_nxt;
  logic [SC_W-1:0]     k_r, k_nxt;
  logic [KEY_W-1:0]    mv_key_r, mv_key_nxt;
  logic [VALUE_W-1:0]  mv_val_r, mv_val_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_found_r, out_found_nxt;

  logic                dir_we;
  logic [DIR_AW-1:0]   dir_waddr, dir_raddr;
  logic [BKT_W-1:0]    dir_wdata, dir_rdata;
  logic                ld_we;
  logic [BKT_W-1:0]    ld_waddr;
  logic [GD_W-1:0]     ld_wdata, ld_rdata;
  logic                mask_we;
  logic [BKT_W-1:0]    mask_waddr;
  logic [S-1:0]        mask_wdata, mask_rdata;
  logic                key_we, val_we;
  logic [SLOT_AW-1:0]  key_waddr, val_waddr, slot_raddr;
  logic [KEY_W-1:0]    key_wdata, key_rdata;
  logic [VALUE_W-1:0]  val_wdata, val_rdata;
  logic                free_we;
  logic [BKT_W-1:0]    free_waddr, free_wdata, free_rdata;

  logic                mix_go, mix_done;
  logic [KEY_W-1:0]    mix_din, mix_dout;

  logic [JW-1:0]       dsize, dmask, hidx, step, mbase, half;
  logic [SI_W-1:0]     cnt_i, ff_i, k_i;
  logic [FCNT_W:0]     tail_sum;
  logic [BKT_W-1:0]    tail;
  logic [BKT_W-1:0]    head_inc;

  assign dsize    = JW'(1) << gd_r;
  assign dmask    = dsize - JW'(1);
  assign hidx     = h_r[JW-1:0] & dmask;
  assign step     = JW'(1) << ld_r;
  assign half     = JW'(1) << (ld_r - GD_W'(1));
  assign mbase    = midx_r & (step - JW'(1));
  assign cnt_i    = cnt_r[SI_W-1:0];
  assign k_i      = k_r[SI_W-1:0];
  assign tail_sum = (FCNT_W+1)'(head_r) + (FCNT_W+1)'(fcnt_r);
  assign tail     = (tail_sum >= (FCNT_W+1)'(BUCKET_POOL))
                    ? BKT_W'(tail_sum - (FCNT_W+1)'(BUCKET_POOL)) : BKT_W'(tail_sum);
  assign head_inc = (head_r == BKT_W'(BUCKET_POOL - 1)) ? '0 : head_r + BKT_W'(1);

  always_comb begin
    ff_i = '0;
    for (int q = S - 1; q >= 0; q--) begin
      if (!mask_r[q]) begin
        ff_i = SI_W'(q);
      end
    end
  end

  assign slot_raddr = slot_addr(b_r, cnt_i);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    h_nxt          = h_r;
    gd_nxt         = gd_r;
    head_nxt       = head_r;
    fcnt_nxt       = fcnt_r;
    dc_nxt         = dc_r;
    clr_nxt        = clr_r;
    clr_bkt_nxt    = clr_bkt_r;
    retry_nxt      = retry_r;
    idx_nxt        = idx_r;
    midx_nxt       = midx_r;
    j_nxt          = j_r;
    b_nxt          = b_r;
    nb_nxt         = nb_r;
    ld_nxt         = ld_r;
    mask_nxt       = mask_r;
    nbmask_nxt     = nbmask_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    mv_key_nxt     = mv_key_r;
    mv_val_nxt     = mv_val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;

    dir_we     = 1'b0;
    dir_waddr  = '0;
    dir_wdata  = '0;
    dir_raddr  = hidx[DIR_AW-1:0];
    ld_we      = 1'b0;
    ld_waddr   = b_r;
    ld_wdata   = ld_r + GD_W'(1);
    mask_we    = 1'b0;
    mask_waddr = b_r;
    mask_wdata = mask_r;
    key_we     = 1'b0;
    val_we     = 1'b0;
    key_waddr  = slot_addr(b_r, ff_i);
    val_waddr  = slot_addr(b_r, ff_i);
    key_wdata  = key_r;
    val_wdata  = val_r;
    free_we    = 1'b0;
    free_waddr = tail;
    free_wdata = b_r;
    mix_go     = 1'b0;
    mix_din    = in_key;

    case (state_r)
      ST_CLEAR: begin
        if (clr_r < MAX_DIRECTORY) begin
          dir_we    = 1'b1;
          dir_waddr = DIR_AW'(clr_r);
          dir_wdata = clr_bkt_r;
        end
        if (clr_r < BUCKET_POOL) begin
          ld_we      = 1'b1;
          ld_waddr   = BKT_W'(clr_r);
          ld_wdata   = GD_W'(INITIAL_DEPTH);
          mask_we    = 1'b1;
          mask_waddr = BKT_W'(clr_r);
          mask_wdata = '0;
        end
        if (clr_r < BUCKET_POOL - INIT_BKTS) begin
          free_we    = 1'b1;
          free_waddr = BKT_W'(clr_r);
          free_wdata = BKT_W'(clr_r) + BKT_W'(INIT_BKTS);
        end
        clr_bkt_nxt = (clr_bkt_r == BKT_W'(BUCKET_POOL - 1)) ? '0 : clr_bkt_r + BKT_W'(1);
        clr_nxt     = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLR_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          mode_nxt  = mode_t'(in_mode);
          key_nxt   = in_key;
          val_nxt   = in_value;
          mix_go    = 1'b1;
          mix_din   = in_key;
          retry_nxt = 1'b0;
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (mix_done) begin
          h_nxt     = mix_dout;
          state_nxt = ST_DIR_RD;
        end
      end
      ST_DIR_RD: begin
        idx_nxt   = hidx;
        state_nxt = ST_DIR_WT;
      end
      ST_DIR_WT: begin
        b_nxt     = dir_rdata;
        state_nxt = ST_BKT_WT;
      end
      ST_BKT_WT: begin
        mask_nxt  = mask_rdata;
        ld_nxt    = ld_rdata;
        cnt_nxt   = '0;
        state_nxt = retry_r ? ST_INS : ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (cnt_r == SC_W'(S)) begin
          if (mode_r == MODE_INSERT) begin
            state_nxt = ST_INS;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_ABSENT;
            out_found_nxt  = '0;
            state_nxt      = ST_IDLE;
          end
        end else if (!mask_r[cnt_i]) begin
          cnt_nxt = cnt_r + SC_W'(1);
        end else begin
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (key_rdata == key_r) begin
          out_found_nxt  = '0;
          out_status_nxt = STAT_DONE;
          case (mode_r)
            MODE_SEARCH: begin
              out_found_nxt = val_rdata;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
            MODE_UPDATE: begin
              val_we        = 1'b1;
              val_waddr     = slot_raddr;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
            MODE_REMOVE: begin
              mask_we    = 1'b1;
              mask_wdata = mask_r & ~(S'(1) << cnt_i);
              midx_nxt   = idx_r;
              state_nxt  = ST_MG_DIR;
            end
            default: begin
              out_status_nxt = STAT_ABSENT;
              out_valid_nxt  = 1'b1;
              state_nxt      = ST_IDLE;
            end
          endcase
        end else begin
          cnt_nxt   = cnt_r + SC_W'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_INS: begin
        if (&mask_r) begin
          state_nxt = ST_SPLIT;
        end else begin
          key_we         = 1'b1;
          val_we         = 1'b1;
          mask_we        = 1'b1;
          mask_wdata     = mask_r | (S'(1) << ff_i);
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DONE;
          out_found_nxt  = '0;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SPLIT: begin
        if ((ld_r >= gd_r && gd_r >= GD_W'(MAX_DEPTH)) || fcnt_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_FULL;
          out_found_nxt  = '0;
          state_nxt      = ST_IDLE;
        end else if (ld_r >= gd_r) begin
          j_nxt     = '0;
          state_nxt = ST_DBL_RD;
        end else begin
          state_nxt = ST_FREE_WT;
        end
      end
      ST_DBL_RD: begin
        dir_raddr = j_r[DIR_AW-1:0];
        state_nxt = ST_DBL_WR;
      end
      ST_DBL_WR: begin
        dir_we    = 1'b1;
        dir_waddr = DIR_AW'(j_r + dsize);
        dir_wdata = dir_rdata;
        j_nxt     = j_r + JW'(1);
        if (j_r + JW'(1) == dsize) begin
          gd_nxt    = gd_r + GD_W'(1);
          state_nxt = ST_FREE_WT;
        end else begin
          state_nxt = ST_DBL_RD;
        end
      end
      ST_FREE_WT: begin
        nb_nxt    = free_rdata;
        head_nxt  = head_inc;
        fcnt_nxt  = fcnt_r - FCNT_W'(1);
        j_nxt     = (idx_r & (step - JW'(1))) | step;
        state_nxt = ST_RELINK;
      end
      ST_RELINK: begin
        if (j_r < dsize) begin
          dir_we    = 1'b1;
          dir_waddr = j_r[DIR_AW-1:0];
          dir_wdata = nb_r;
          j_nxt     = j_r + (step << 1);
        end else begin
          state_nxt = ST_LD_B;
        end
      end
      ST_LD_B: begin
        ld_we     = 1'b1;
        state_nxt = ST_LD_NB;
      end
      ST_LD_NB: begin
        ld_we     = 1'b1;
        ld_waddr  = nb_r;
        state_nxt = ST_DC_DEC;
      end
      ST_DC_DEC: begin
        dc_nxt[ld_r] = dc_r[ld_r] - FCNT_W'(1);
        state_nxt    = ST_DC_INC;
      end
      ST_DC_INC: begin
        dc_nxt[ld_r + GD_W'(1)] = dc_r[ld_r + GD_W'(1)] + FCNT_W'(2);
        cnt_nxt                 = '0;
        k_nxt                   = '0;
        nbmask_nxt              = '0;
        state_nxt               = ST_MV_RD;
      end
      ST_MV_RD: begin
        if (cnt_r == SC_W'(S)) begin
          state_nxt = ST_MASK_B;
        end else if (!mask_r[cnt_i]) begin
          cnt_nxt = cnt_r + SC_W'(1);
        end else begin
          state_nxt = ST_MV_WT;
        end
      end
      ST_MV_WT: begin
        mv_key_nxt = key_rdata;
        mv_val_nxt = val_rdata;
        mix_go     = 1'b1;
        mix_din    = key_rdata;
        state_nxt  = ST_MV_HASH;
      end
      ST_MV_HASH: begin
        if (mix_done) begin
          if (mix_dout[6'(ld_r)]) begin
            key_we     = 1'b1;
            val_we     = 1'b1;
            key_waddr  = slot_addr(nb_r, k_i);
            val_waddr  = slot_addr(nb_r, k_i);
            key_wdata  = mv_key_r;
            val_wdata  = mv_val_r;
            nbmask_nxt = nbmask_r | (S'(1) << k_i);
            mask_nxt   = mask_r & ~(S'(1) << cnt_i);
            k_nxt      = k_r + SC_W'(1);
          end
          cnt_nxt   = cnt_r + SC_W'(1);
          state_nxt = ST_MV_RD;
        end
      end
      ST_MASK_B: begin
        mask_we   = 1'b1;
        state_nxt = ST_MASK_NB;
      end
      ST_MASK_NB: begin
        mask_we    = 1'b1;
        mask_waddr = nb_r;
        mask_wdata = nbmask_r;
        retry_nxt  = 1'b1;
        state_nxt  = ST_DIR_RD;
      end
      ST_MG_DIR: begin
        dir_raddr = DIR_AW'(midx_r & dmask);
        state_nxt = ST_MG_DWT;
      end
      ST_MG_DWT: begin
        b_nxt     = dir_rdata;
        state_nxt = ST_MG_BWT;
      end
      ST_MG_BWT: begin
        ld_nxt   = ld_rdata;
        mask_nxt = mask_rdata;
        if (ld_rdata <= GD_W'(INITIAL_DEPTH) || ld_rdata > gd_r || mask_rdata != '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DONE;
          out_found_nxt  = '0;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_MG_BUD;
        end
      end
      ST_MG_BUD: begin
        dir_raddr = DIR_AW'(mbase ^ half);
        j_nxt     = mbase;
        state_nxt = ST_MG_BWT2;
      end
      ST_MG_BWT2: begin
        nb_nxt    = dir_rdata;
        state_nxt = ST_MG_LDWT;
      end
      ST_MG_LDWT: begin
        if (ld_rdata != ld_r || nb_r == b_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DONE;
          out_found_nxt  = '0;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_MG_RELINK;
        end
      end
      ST_MG_RELINK: begin
        if (j_r < dsize) begin
          dir_we    = 1'b1;
          dir_waddr = j_r[DIR_AW-1:0];
          dir_wdata = nb_r;
          j_nxt     = j_r + step;
        end else begin
          state_nxt = ST_MG_FREE;
        end
      end
      ST_MG_FREE: begin
        free_we = 1'b1;
        if (fcnt_r < FCNT_W'(BUCKET_POOL)) begin
          fcnt_nxt = fcnt_r + FCNT_W'(1);
        end
        state_nxt = ST_MG_DC1;
      end
      ST_MG_DC1: begin
        dc_nxt[ld_r] = dc_r[ld_r] - FCNT_W'(2);
        state_nxt    = ST_MG_DC2;
      end
      ST_MG_DC2: begin
        dc_nxt[ld_r - GD_W'(1)] = dc_r[ld_r - GD_W'(1)] + FCNT_W'(1);
        state_nxt               = ST_MG_LD;
      end
      ST_MG_LD: begin
        ld_we     = 1'b1;
        ld_waddr  = nb_r;
        ld_wdata  = ld_r - GD_W'(1);
        state_nxt = ST_MG_GD;
      end
      ST_MG_GD: begin
        if (gd_r > GD_W'(INITIAL_DEPTH) && dc_r[gd_r] == '0) begin
          gd_nxt = gd_r - GD_W'(1);
        end else begin
          midx_nxt  = mbase & (half - JW'(1));
          state_nxt = ST_MG_DIR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      gd_r        <= GD_W'(INITIAL_DEPTH);
      head_r      <= '0;
      fcnt_r      <= FCNT_W'(BUCKET_POOL - INIT_BKTS);
      clr_r       <= '0;
      clr_bkt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int d = 0; d <= MAX_DEPTH; d++) begin
        dc_r[d] <= (d == INITIAL_DEPTH) ? FCNT_W'(INIT_BKTS) : '0;
      end
    end else begin
      state_r     <= state_nxt;
      gd_r        <= gd_nxt;
      head_r      <= head_nxt;
      fcnt_r      <= fcnt_nxt;
      clr_r       <= clr_nxt;
      clr_bkt_r   <= clr_bkt_nxt;
      out_valid_r <= out_valid_nxt;
      dc_r        <= dc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    h_r          <= h_nxt;
    retry_r      <= retry_nxt;
    idx_r        <= idx_nxt;
    midx_r       <= midx_nxt;
    j_r          <= j_nxt;
    b_r          <= b_nxt;
    nb_r         <= nb_nxt;
    ld_r         <= ld_nxt;
    mask_r       <= mask_nxt;
    nbmask_r     <= nbmask_nxt;
    cnt_r        <= cnt_nxt;
    k_r          <= k_nxt;
    mv_key_r     <= mv_key_nxt;
    mv_val_r     <= mv_val_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  ehash_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mix_go),
    .din   (mix_din),
    .done  (mix_done),
    .dout  (mix_dout)
  );

  ehash_ram #(.WIDTH(BKT_W), .DEPTH(MAX_DIRECTORY)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  ehash_ram #(.WIDTH(GD_W), .DEPTH(BUCKET_POOL)) u_ld_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_waddr),
    .wdata (ld_wdata),
    .raddr (dir_rdata),
    .rdata (ld_rdata)
  );

  ehash_ram #(.WIDTH(S), .DEPTH(BUCKET_POOL)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .raddr (dir_rdata),
    .rdata (mask_rdata)
  );

  ehash_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (slot_raddr),
    .rdata (key_rdata)
  );

  ehash_ram #(.WIDTH(VALUE_W), .DEPTH(SLOT_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (slot_raddr),
    .rdata (val_rdata)
  );

  ehash_ram #(.WIDTH(BKT_W), .DEPTH(BUCKET_POOL)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (head_r),
    .rdata (free_rdata)
  );

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while a command is still running");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_found_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_DONE) |-> (out_found_value == '0))
    else $error("nonzero found value on a miss");

  a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FCNT_W'(BUCKET_POOL))
    else $error("free queue count above pool size");

endmodule
